// ===== hdl/hopf_oscillator_rk4_step_assert.svh =====
// ----------------------------------------------------------------------------
// hopf oscillator assertion macros
// shared property shorthands for the port checker
// ----------------------------------------------------------------------------
`ifndef HOPF_OSCILLATOR_RK4_STEP_ASSERT_SVH
`define HOPF_OSCILLATOR_RK4_STEP_ASSERT_SVH

// same-cycle implication
`define HOSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hosc assertion failed");

// next-cycle implication
`define HOSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hosc assertion failed");

`endif

// ===== hdl/hosc_pkg.sv =====
// ----------------------------------------------------------------------------
// hosc_pkg
// types, constants and the cordic arctangent table of the hopf oscillator
// ----------------------------------------------------------------------------
package hosc_pkg;

  localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;

  localparam logic signed [31:0] RST_GROWTH = 32'sd0;
  localparam logic signed [31:0] RST_CUBIC  = 32'sd16777216;
  localparam logic [30:0]        RST_STEP   = 31'd167772;
  localparam logic [31:0]        RST_PSTEP  = 32'd0;
  localparam logic [30:0]        RST_AMP    = 31'd167772;
  localparam logic [31:0]        RST_PHASE  = 32'd0;

  // ceil(2^34 / 3) split into low 17 and high 16 bits, for the divide by six
  localparam logic [16:0]        DIV3_ML    = 17'h15556;
  localparam logic [15:0]        DIV3_MH    = 16'hAAAA;

  typedef enum logic [2:0] {
    REG_GROWTH = 3'd0,
    REG_CUBIC  = 3'd1,
    REG_STEP   = 3'd2,
    REG_PSTEP  = 3'd3,
    REG_AMP0   = 3'd4,
    REG_PHASE0 = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DIV,
    ST_UPDATE,
    ST_PISSUE,
    ST_PWAIT,
    ST_CWAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_SQ,
    OP_CUBE,
    OP_LIN,
    OP_CUB,
    OP_STEP
  } op_t;

  typedef struct packed {
    logic               start;
    logic               kinv_sel;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/hosc_mul.sv =====
// ----------------------------------------------------------------------------
// hosc_mul
// shared fixed-point multiplier: operand, product and floor-shift/saturate stages
// ----------------------------------------------------------------------------
module hosc_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hosc_pkg::mul_req_t req,
  output logic               done,
  output logic signed [31:0] res
);

  logic signed [31:0] a_r, b_r;
  logic               sel_r, sel2_r;
  logic               st1_r, st2_r, done_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] shifted;
  logic signed [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r  <= 1'b0;
      st2_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st1_r  <= req.start;
      st2_r  <= st1_r;
      done_r <= st2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      sel_r <= req.kinv_sel;
    end
    if (st1_r) begin
      prod_r <= a_r * b_r;
      sel2_r <= sel_r;
    end
    if (st2_r) begin
      if ((shifted[63:31] != '0) && (shifted[63:31] != '1)) begin
        res_r <= shifted[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        res_r <= shifted[31:0];
      end
    end
  end

  assign shifted = sel2_r ? (prod_r >>> 30) : (prod_r >>> FRAC_BITS);
  assign done    = done_r;
  assign res     = res_r;

endmodule

// ===== hdl/hosc_cordic.sv =====
// ----------------------------------------------------------------------------
// hosc_cordic
// quarter-turn fold then iterative rotation-mode cordic, one iteration a cycle
// ----------------------------------------------------------------------------
module hosc_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] mag,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [31:0] re,
  output logic signed [31:0] im
);

  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic               busy_r, done_r;
  logic [4:0]         idx_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic [31:0]        rnd;
  logic [1:0]         quad;
  logic [31:0]        resid;
  logic signed [33:0] m_ext, xs, ys, at;

  assign rnd   = phase + 32'h20000000;
  assign quad  = rnd[31:30];
  assign resid = phase - {quad, 30'd0};
  assign m_ext = {{2{mag[31]}}, mag};
  assign xs    = x_r >>> idx_r;
  assign ys    = y_r >>> idx_r;
  assign at    = {2'b00, hosc_pkg::atan_turns(idx_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (idx_r == LAST)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r <= '0;
      z_r   <= {{2{resid[31]}}, resid};
      case (quad)
        2'd0: begin
          x_r <= m_ext;
          y_r <= '0;
        end
        2'd1: begin
          x_r <= '0;
          y_r <= m_ext;
        end
        2'd2: begin
          x_r <= -m_ext;
          y_r <= '0;
        end
        default: begin
          x_r <= '0;
          y_r <= -m_ext;
        end
      endcase
    end else if (busy_r) begin
      idx_r <= idx_r + 5'd1;
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  always_comb begin
    if ((x_r[33:31] != 3'b000) && (x_r[33:31] != 3'b111)) begin
      re = x_r[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      re = x_r[31:0];
    end
    if ((y_r[33:31] != 3'b000) && (y_r[33:31] != 3'b111)) begin
      im = y_r[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      im = y_r[31:0];
    end
  end

  assign done = done_r;

endmodule

// ===== hdl/hopf_oscillator_rk4_step.sv =====
// ----------------------------------------------------------------------------
// hopf_oscillator_rk4_step
// hopf normal-form oscillator: rk4 amplitude step, phase advance, cordic output
// ----------------------------------------------------------------------------
// channel  direction  width  contents
// in_      slave      8      restart in bit 0
// out_     master     128    real, imag, amplitude, phase
// cfg_     apb        32     six registers at byte address 4*i
//
// an advance transaction runs twenty rk4 multiplies on the one shared
// multiplier, a reciprocal multiply in two halves for the divide by six
// and a gain multiply, then one iteration a cycle in the cordic. a restart
// loads amplitude and phase, then runs only the gain multiply and the
// cordic. reset is synchronous; in_tready is high only while idle, and a
// finished result waits in the output register while out_tready is low.
// ----------------------------------------------------------------------------
module hopf_oscillator_rk4_step #(
  parameter int FRAC_BITS    = 24,
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,   // real_part, imag_part, amplitude_out, phase_out
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  hosc_pkg::state_t   state_r, state_nxt;
  hosc_pkg::op_t      op_r;
  hosc_pkg::mul_req_t mreq;

  logic signed [31:0] sigma_r, gcoef_r;
  logic [30:0]        dt_r, a0_r, amp_r;
  logic [31:0]        pstep_r, p0_r, ph_r;
  logic [2:0]         cfg_idx;
  logic               cfg_wr;

  logic [1:0]         stage_r;
  logic signed [31:0] x_r, sq_r, cube_r, lin_r, cub_r;
  logic signed [34:0] acc_r;
  logic [32:0]        dv_r;
  logic [65:0]        qacc_r;
  logic               dcnt_r;
  logic               neg_r;

  logic               mul_done, cor_done, cor_start;
  logic signed [31:0] mul_res, cor_re, cor_im;

  logic               out_valid_r;
  logic [127:0]       out_data_r;

  logic               in_acc, out_load;
  logic signed [32:0] fdiff;
  logic signed [31:0] fval;
  logic signed [32:0] xsum;
  logic signed [31:0] xsat;
  logic signed [34:0] k_ext, acc_nxt;
  logic [33:0]        mag;
  logic [16:0]        dmul;
  logic [49:0]        pm;
  logic [31:0]        quo;
  logic signed [35:0] qs, rn;

  // configuration port
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= hosc_pkg::RST_GROWTH;
      gcoef_r <= hosc_pkg::RST_CUBIC;
      dt_r    <= hosc_pkg::RST_STEP;
      pstep_r <= hosc_pkg::RST_PSTEP;
      a0_r    <= hosc_pkg::RST_AMP;
      p0_r    <= hosc_pkg::RST_PHASE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hosc_pkg::REG_GROWTH: sigma_r <= cfg_pwdata;
        hosc_pkg::REG_CUBIC:  gcoef_r <= cfg_pwdata;
        hosc_pkg::REG_STEP:   dt_r    <= cfg_pwdata[30:0];
        hosc_pkg::REG_PSTEP:  pstep_r <= cfg_pwdata;
        hosc_pkg::REG_AMP0:   a0_r    <= cfg_pwdata[30:0];
        hosc_pkg::REG_PHASE0: p0_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hosc_pkg::REG_GROWTH: cfg_prdata = sigma_r;
      hosc_pkg::REG_CUBIC:  cfg_prdata = gcoef_r;
      hosc_pkg::REG_STEP:   cfg_prdata = {1'b0, dt_r};
      hosc_pkg::REG_PSTEP:  cfg_prdata = pstep_r;
      hosc_pkg::REG_AMP0:   cfg_prdata = {1'b0, a0_r};
      hosc_pkg::REG_PHASE0: cfg_prdata = p0_r;
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // shared arithmetic units
  hosc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mul_done),
    .res  (mul_res)
  );

  hosc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cor_start),
    .mag  (mul_res),
    .phase(ph_r),
    .done (cor_done),
    .re   (cor_re),
    .im   (cor_im)
  );

  // datapath helpers
  assign fdiff = {lin_r[31], lin_r} - {cub_r[31], cub_r};
  always_comb begin
    if (fdiff[32] != fdiff[31]) begin
      fval = fdiff[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      fval = fdiff[31:0];
    end
  end

  assign k_ext = {{3{mul_res[31]}}, mul_res};
  always_comb begin
    if (stage_r == 2'd2) begin
      xsum = {2'b00, amp_r} + {mul_res[31], mul_res};
    end else begin
      xsum = {2'b00, amp_r} + {{2{mul_res[31]}}, mul_res[31:1]};
    end
    if (xsum[32] != xsum[31]) begin
      xsat = xsum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      xsat = xsum[31:0];
    end
    case (stage_r)
      2'd0:    acc_nxt = k_ext;
      2'd3:    acc_nxt = acc_r + k_ext;
      default: acc_nxt = acc_r + (k_ext <<< 1);
    endcase
  end

  // divide by six: halve, then multiply by the reciprocal of three
  assign mag  = acc_nxt[34] ? 34'(-acc_nxt) : 34'(acc_nxt);
  assign dmul = dcnt_r ? {1'b0, hosc_pkg::DIV3_MH} : hosc_pkg::DIV3_ML;
  assign pm   = dv_r * dmul;
  assign quo  = qacc_r[65:34];
  assign qs   = neg_r ? -$signed({4'd0, quo}) : $signed({4'd0, quo});
  assign rn   = $signed({5'd0, amp_r}) + qs;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hosc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_tdata[0] ? hosc_pkg::ST_PISSUE : hosc_pkg::ST_ISSUE;
        end
      end
      hosc_pkg::ST_ISSUE: state_nxt = hosc_pkg::ST_WAIT;
      hosc_pkg::ST_WAIT: begin
        if (mul_done) begin
          if ((op_r == hosc_pkg::OP_STEP) && (stage_r == 2'd3)) begin
            state_nxt = hosc_pkg::ST_DIV;
          end else begin
            state_nxt = hosc_pkg::ST_ISSUE;
          end
        end
      end
      hosc_pkg::ST_DIV: begin
        if (dcnt_r) begin
          state_nxt = hosc_pkg::ST_UPDATE;
        end
      end
      hosc_pkg::ST_UPDATE: state_nxt = hosc_pkg::ST_PISSUE;
      hosc_pkg::ST_PISSUE: state_nxt = hosc_pkg::ST_PWAIT;
      hosc_pkg::ST_PWAIT: begin
        if (mul_done) begin
          state_nxt = hosc_pkg::ST_CWAIT;
        end
      end
      hosc_pkg::ST_CWAIT: begin
        if (cor_done) begin
          state_nxt = hosc_pkg::ST_DONE;
        end
      end
      hosc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = hosc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hosc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready     = (state_r == hosc_pkg::ST_IDLE);
    cor_start     = (state_r == hosc_pkg::ST_PWAIT) && mul_done;
    out_load      = (state_r == hosc_pkg::ST_DONE) && (!out_valid_r || out_tready);
    mreq.start    = (state_r == hosc_pkg::ST_ISSUE) || (state_r == hosc_pkg::ST_PISSUE);
    mreq.kinv_sel = (state_r == hosc_pkg::ST_PISSUE);
    if (state_r == hosc_pkg::ST_PISSUE) begin
      mreq.a = $signed({1'b0, amp_r});
      mreq.b = hosc_pkg::KINV_Q30;
    end else begin
      case (op_r)
        hosc_pkg::OP_SQ: begin
          mreq.a = x_r;
          mreq.b = x_r;
        end
        hosc_pkg::OP_CUBE: begin
          mreq.a = sq_r;
          mreq.b = x_r;
        end
        hosc_pkg::OP_LIN: begin
          mreq.a = sigma_r;
          mreq.b = x_r;
        end
        hosc_pkg::OP_CUB: begin
          mreq.a = gcoef_r;
          mreq.b = cube_r;
        end
        default: begin
          mreq.a = $signed({1'b0, dt_r});
          mreq.b = fval;
        end
      endcase
    end
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hosc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      amp_r       <= hosc_pkg::RST_AMP;
      ph_r        <= hosc_pkg::RST_PHASE;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && in_tdata[0]) begin
        amp_r <= a0_r;
        ph_r  <= p0_r;
      end else if (state_r == hosc_pkg::ST_UPDATE) begin
        ph_r <= ph_r + pstep_r;
        if (rn[35]) begin
          amp_r <= '0;
        end else if (rn[35:31] != 5'd0) begin
          amp_r <= '1;
        end else begin
          amp_r <= rn[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= $signed({1'b0, amp_r});
      stage_r <= 2'd0;
      op_r    <= hosc_pkg::OP_SQ;
    end
    if ((state_r == hosc_pkg::ST_WAIT) && mul_done) begin
      case (op_r)
        hosc_pkg::OP_SQ: begin
          sq_r <= mul_res;
          op_r <= hosc_pkg::OP_CUBE;
        end
        hosc_pkg::OP_CUBE: begin
          cube_r <= mul_res;
          op_r   <= hosc_pkg::OP_LIN;
        end
        hosc_pkg::OP_LIN: begin
          lin_r <= mul_res;
          op_r  <= hosc_pkg::OP_CUB;
        end
        hosc_pkg::OP_CUB: begin
          cub_r <= mul_res;
          op_r  <= hosc_pkg::OP_STEP;
        end
        default: begin
          acc_r   <= acc_nxt;
          x_r     <= xsat;
          stage_r <= stage_r + 2'd1;
          op_r    <= hosc_pkg::OP_SQ;
          neg_r   <= acc_nxt[34];
          dv_r    <= mag[33:1];
          dcnt_r  <= 1'b0;
        end
      endcase
    end
    if (state_r == hosc_pkg::ST_DIV) begin
      if (dcnt_r) begin
        qacc_r <= qacc_r + {pm[48:0], 17'd0};
      end else begin
        qacc_r <= {16'd0, pm};
      end
      dcnt_r <= 1'b1;
    end
    if (out_load) begin
      out_data_r <= {1'b0, ph_r, amp_r, cor_im, cor_re};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/hosc_checker.sv =====
// ----------------------------------------------------------------------------
// hosc_checker
// port-level checks of the hopf oscillator, bound to the top level
// ----------------------------------------------------------------------------
`include "hopf_oscillator_rk4_step_assert.svh"

module hosc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         cfg_pready
);

  `HOSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `HOSC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `HOSC_ASSERT_NOW(a_pad_zero, out_tvalid, !out_tdata[127])
  `HOSC_ASSERT_NOW(a_pready_high, 1'b1, cfg_pready)

endmodule

bind hopf_oscillator_rk4_step hosc_checker u_hosc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .cfg_pready(cfg_pready)
);
